/* rtl/core/sspq_pkg.sv */
package sspq_pkg;

    // Queue depth and the width of the entry counter.
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    // Command codes of an input beat.
    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CLR = 2'd2
    } t_cmd;

    // Status codes of a result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic [DATA_W-1:0] rank;
        logic [DATA_W-1:0] payload;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctrl;

endpackage

/* rtl/core/sspq_ifs.sv */
// Input channel: command, payload and rank with a valid/ready handshake.
interface sspq_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [sspq_pkg::DATA_W-1:0]   payload;
    logic [sspq_pkg::DATA_W-1:0]   rank;

    modport source (output valid, command, payload, rank, input ready);
    modport sink   (input valid, command, payload, rank, output ready);
endinterface

// Result channel: status, removed head payload and occupancy.
interface sspq_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [sspq_pkg::DATA_W-1:0]   head_payload;
    logic [sspq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, head_payload, occupancy, input ready);
    modport sink   (input valid, status, head_payload, occupancy, output ready);
endinterface

/* rtl/core/sspq_cell.sv */
module sspq_cell (
    input  logic                  i_clk,
    input  sspq_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_occ,
    input  sspq_pkg::t_entry      i_left,
    input  logic                  i_left_keep,
    input  sspq_pkg::t_entry      i_right,
    output sspq_pkg::t_entry      o_entry,
    output logic                  o_keep
);

    sspq_pkg::t_entry r_entry;
    sspq_pkg::t_entry n_entry;

    // An occupied cell whose rank is not above the new one stays in place.
    assign o_keep  = i_occ && (r_entry.rank <= i_ctrl.item.rank);
    assign o_entry = r_entry;

    // Insert: take the new entry at the boundary, else shift in from the left.
    // Remove: shift in from the right.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_ctrl.item : i_left;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/core/stable_sorted_priority_queue.sv */
// Bounded priority queue kept sorted in ascending rank order.
// Input channel i_in carries a command (enqueue, dequeue, clear), a payload
// and a rank; result channel o_out carries a status, the payload of a
// removed head and the occupancy after the command. Every input beat gives
// exactly one result beat. Entries of equal rank leave in arrival order.
// The entries live in a row of cells; each cell compares its rank with the
// incoming one and either holds, takes the new entry or takes its neighbor,
// so an insert or a removal updates every cell at the same clock edge.
// A valid result beat appears in the cycle after an input beat is accepted.
// Throughput is one beat per cycle while the receiver takes each result; the single result register sets it.
// When the receiver stalls, the result register holds and i_in.ready drops
// until that result beat is taken; a new input beat is accepted in the same
// cycle as the held result leaves.
// Synchronous active-low reset empties the queue and drops any pending
// result; the stored entries need no clearing since only occupied cells are
// ever read.
module stable_sorted_priority_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sspq_in_if.sink      i_in,
    sspq_out_if.source   o_out
);

    localparam int N = sspq_pkg::CAPACITY;

    logic [sspq_pkg::CNT_W-1:0]   r_count;
    logic [sspq_pkg::CNT_W-1:0]   n_count;
    logic                         r_out_valid;
    logic [1:0]                   r_status;
    logic [1:0]                   n_status;
    logic [sspq_pkg::DATA_W-1:0]  r_head;
    logic [sspq_pkg::DATA_W-1:0]  n_head;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    sspq_pkg::t_cell_ctrl         w_ctrl;
    sspq_pkg::t_entry             w_entry [N];
    logic [N-1:0]                 w_keep;
    logic [N-1:0]                 w_occ;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_full   = (r_count == sspq_pkg::CNT_W'(N));
    assign w_empty  = (r_count == '0);
    assign i_in.ready = !r_out_valid || o_out.ready;

    // Command broadcast to the cell row, gated off for dropped commands.
    always_comb begin
        w_ctrl.enq          = w_accept && (i_in.command == sspq_pkg::CMD_ENQ) && !w_full;
        w_ctrl.deq          = w_accept && (i_in.command == sspq_pkg::CMD_DEQ) && !w_empty;
        w_ctrl.item.rank    = i_in.rank;
        w_ctrl.item.payload = i_in.payload;
    end

    // Cell row: cell 0 is the head.
    for (genvar g = 0; g < N; g++) begin : g_cell
        assign w_occ[g] = (sspq_pkg::CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            sspq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_occ       (w_occ[g]),
                .i_left      (w_ctrl.item),
                .i_left_keep (1'b1),
                .i_right     (w_entry[(N > 1) ? 1 : 0]),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
        end else if (g == N - 1) begin : g_tail
            sspq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_occ       (w_occ[g]),
                .i_left      (w_entry[g-1]),
                .i_left_keep (w_keep[g-1]),
                .i_right     (w_entry[g]),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
        end else begin : g_mid
            sspq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_occ       (w_occ[g]),
                .i_left      (w_entry[g-1]),
                .i_left_keep (w_keep[g-1]),
                .i_right     (w_entry[g+1]),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
        end
    end

    // Next count, status and removed head for the accepted beat.
    always_comb begin
        n_count  = r_count;
        n_status = sspq_pkg::ST_OK;
        n_head   = '0;
        case (i_in.command)
            sspq_pkg::CMD_ENQ: begin
                if (w_full) begin
                    n_status = sspq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            sspq_pkg::CMD_DEQ: begin
                if (w_empty) begin
                    n_status = sspq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    n_head  = w_entry[0].payload;
                end
            end
            sspq_pkg::CMD_CLR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Count and result-valid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_head   <= n_head;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.head_payload = r_head;
    assign o_out.occupancy    = sspq_pkg::OCC_W'(r_count);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sspq_pkg::CNT_W'(N))
        else $error("entry count above capacity");

    // Every accepted beat yields a result beat in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("no result after accepted beat");

    // A full status reports an occupancy equal to the capacity.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == sspq_pkg::ST_FULL) |->
            (o_out.occupancy == sspq_pkg::OCC_W'(N)))
        else $error("full status with wrong occupancy");

    // An empty-queue dequeue leaves the queue empty.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == sspq_pkg::ST_EMPTY) |->
            (r_count == '0 && r_head == '0))
        else $error("empty status on nonempty queue");

endmodule
